[hw/rtl/fsr_pkg.sv]
`timescale 1ns / 1ps

package fsr_pkg;

   localparam int MAX_TAPS_DEF    = 5;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int COEF_BITS      = 16;
   localparam int COEF_FRAC      = 14;
   localparam int TAP_BITS       = 3;
   localparam int OFFSET_BITS    = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_TAP_COUNT    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OFFSET_MODE  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FIXED_OFFSET = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_BASE    = 3'd3;

   localparam logic [TAP_BITS-1:0] TAP_COUNT_RESET = 3'd5;

   typedef enum logic [1:0] {
      OFS_FIXED  = 2'd0,
      OFS_NONE   = 2'd1,
      OFS_MIDDLE = 2'd2,
      OFS_LAST   = 2'd3
   } offset_mode_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

[hw/rtl/fsr_channels.sv]
`timescale 1ns / 1ps

interface fsr_req_if
   import fsr_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          end_of_frame;

   modport source (output valid, sample, end_of_frame, input ready);
   modport sink   (input valid, sample, end_of_frame, output ready);
endinterface

interface fsr_rsp_if
   import fsr_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic signed [SAMPLE_BITS-1:0] filtered;
   logic signed [SAMPLE_BITS:0]   residual_value;

   modport source (output valid, filtered, residual_value, input ready);
   modport sink   (input valid, filtered, residual_value, output ready);
endinterface

interface fsr_csr_if
   import fsr_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/fsr_cell.sv]
`timescale 1ns / 1ps

module fsr_cell
   import fsr_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                    clock,
   input  cell_ctl_type                            ctl,
   input  logic signed [SAMPLE_BITS-1:0]           sample_in,
   input  logic signed [COEF_BITS-1:0]             coef,
   input  logic                                    tap_used,
   output logic signed [SAMPLE_BITS-1:0]           sample_out,
   output logic signed [SAMPLE_BITS+COEF_BITS-1:0] product_out
);

   logic signed [SAMPLE_BITS-1:0]           sample_ff;
   logic signed [SAMPLE_BITS+COEF_BITS-1:0] product_ff;

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         sample_ff <= sample_in;
      end
      if (ctl.load) begin
         if (tap_used) begin
            product_ff <= sample_ff * coef;
         end else begin
            product_ff <= '0;
         end
      end
   end

   assign sample_out  = sample_ff;
   assign product_out = product_ff;

endmodule

[hw/rtl/fsr_sum.sv]
`timescale 1ns / 1ps

module fsr_sum
   import fsr_pkg::*;
#(
   parameter int MAX_TAPS    = MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic signed [SAMPLE_BITS+COEF_BITS-1:0] products [MAX_TAPS],
   input  logic signed [SAMPLE_BITS-1:0]           resid_sample,
   fsr_rsp_if.source                               rsp_ch
);

   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS  = PROD_BITS + 3;
   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1 << (COEF_FRAC - 1));
   localparam logic signed [ACC_BITS-1:0] F_MAX = ACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [ACC_BITS-1:0] F_MIN = ACC_BITS'(-(1 << (SAMPLE_BITS - 1)));

   logic                          c_valid_ff, c_valid_in;
   logic signed [ACC_BITS-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] c_resid_ff;
   logic                          out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] filtered_ff, filtered_in;
   logic signed [SAMPLE_BITS:0]   residual_ff, residual_in;
   logic signed [ACC_BITS-1:0]    rounded;
   logic                          d_ready, c_ready, c_load, d_load;

   assign d_ready  = !out_valid_ff || rsp_ch.ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;
   assign c_load   = in_valid && c_ready;
   assign d_load   = c_valid_ff && d_ready;

   // rounding constant rides along with the tap sum
   always_comb begin
      sum_in = ROUND_HALF;
      for (int k = 0; k < MAX_TAPS; k++) begin
         sum_in = sum_in + ACC_BITS'(products[k]);
      end
   end

   always_comb begin
      rounded = sum_ff >>> COEF_FRAC;
      priority if (rounded > F_MAX) begin
         filtered_in = SAMPLE_BITS'(F_MAX);
      end else if (rounded < F_MIN) begin
         filtered_in = SAMPLE_BITS'(F_MIN);
      end else begin
         filtered_in = SAMPLE_BITS'(rounded);
      end
      residual_in = (SAMPLE_BITS+1)'(c_resid_ff) - (SAMPLE_BITS+1)'(filtered_in);
   end

   always_comb begin
      c_valid_in = c_valid_ff;
      if (c_load) begin
         c_valid_in = 1'b1;
      end else if (d_load) begin
         c_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (d_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         c_valid_ff   <= c_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (c_load) begin
         sum_ff     <= sum_in;
         c_resid_ff <= resid_sample;
      end
      if (d_load) begin
         filtered_ff <= filtered_in;
         residual_ff <= residual_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.filtered       = filtered_ff;
   assign rsp_ch.residual_value = residual_ff;

endmodule

[hw/rtl/fir_smoother_with_residual_top.sv]
`timescale 1ns / 1ps
// channel  | dir | handshake    | payload
// req_ch   | in  | valid/ready  | sample, end_of_frame
// rsp_ch   | out | valid/ready  | filtered, residual_value
// csr_ch   | in  | valid/ready  | index, data (ready always high)
//
// one sample per cycle unless rsp_ch back-pressure fills the pipe; a result is registered
// in the cell products, tap sum and round/saturate/residual stages, held while rsp_ch stalls.
// the stages hand off by valid/ready, so input is held back only once every
// stage up to the output register is full.
// synchronous reset clears the control registers, fill count and stage valids;
// the cell sample and product registers and the other data registers are not reset.

module fir_smoother_with_residual_top
   import fsr_pkg::*;
#(
   parameter int MAX_TAPS    = MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   fsr_req_if.sink   req_ch,
   fsr_rsp_if.source rsp_ch,
   fsr_csr_if.sink   csr_ch
);

   localparam int IDX_BITS  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;

   logic [TAP_BITS-1:0]           tap_count_ff;
   offset_mode_type               offset_mode_ff;
   logic [OFFSET_BITS-1:0]        fixed_offset_ff;
   logic signed [COEF_BITS-1:0]   coef_ff [MAX_TAPS];

   logic [TAP_BITS-1:0]           fill_ff, fill_in, fill_pre;
   logic                          a_valid_ff, a_valid_in;
   logic                          b_valid_ff, b_valid_in;
   logic signed [SAMPLE_BITS-1:0] b_resid_ff, resid_sel;

   logic [TAP_BITS-1:0]           taps, offset, resid_idx;
   logic                          accept, fire, b_load, b_ready, sum_ready;
   cell_ctl_type                  cell_ctl;

   logic signed [SAMPLE_BITS-1:0] chain   [MAX_TAPS+1];
   logic signed [PROD_BITS-1:0]   product [MAX_TAPS];
   logic signed [COEF_BITS-1:0]   coef_sel [MAX_TAPS];
   logic                          tap_used [MAX_TAPS];

   // register file
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff    <= TAP_COUNT_RESET;
         offset_mode_ff  <= OFS_NONE;
         fixed_offset_ff <= '0;
         for (int k = 0; k < MAX_TAPS; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (csr_ch.valid) begin
         priority if (csr_ch.index == REG_TAP_COUNT) begin
            tap_count_ff <= csr_ch.data[TAP_BITS-1:0];
         end else if (csr_ch.index == REG_OFFSET_MODE) begin
            offset_mode_ff <= offset_mode_type'(csr_ch.data[1:0]);
         end else if (csr_ch.index == REG_FIXED_OFFSET) begin
            fixed_offset_ff <= csr_ch.data[OFFSET_BITS-1:0];
         end else begin
            for (int k = 0; k < MAX_TAPS; k++) begin
               if (int'(csr_ch.index) == int'(REG_COEF_BASE) + k) begin
                  coef_ff[k] <= csr_ch.data;
               end
            end
         end
      end
   end

   // effective tap count and residual offset
   always_comb begin
      priority if (tap_count_ff == '0) begin
         taps = TAP_BITS'(1);
      end else if (int'(tap_count_ff) > MAX_TAPS) begin
         taps = TAP_BITS'(MAX_TAPS);
      end else begin
         taps = tap_count_ff;
      end
      unique case (offset_mode_ff)
         OFS_FIXED:  offset = (fixed_offset_ff > taps - 1'b1) ? taps - 1'b1 : fixed_offset_ff;
         OFS_NONE:   offset = '0;
         OFS_MIDDLE: offset = taps >> 1;
         OFS_LAST:   offset = taps - 1'b1;
         default:    offset = '0;
      endcase
      // window slot j sits in cell taps-1-j (cell 0 holds the newest sample)
      resid_idx = taps - 1'b1 - offset;
   end

   always_comb begin
      int j;
      resid_sel = chain[1];
      for (int k = 0; k < MAX_TAPS; k++) begin
         j = int'(taps) - 1 - k;
         tap_used[k] = (j >= 0);
         coef_sel[k] = (j >= 0) ? coef_ff[IDX_BITS'(j)] : '0;
         if (int'(resid_idx) == k) begin
            resid_sel = chain[k+1];
         end
      end
   end

   // fill tracking and stage handshake
   assign b_ready    = !b_valid_ff || sum_ready;
   assign req_ch.ready = !a_valid_ff || b_ready;
   assign accept     = req_ch.valid && req_ch.ready;
   assign b_load     = a_valid_ff && b_ready;
   assign fill_pre   = (fill_ff >= taps) ? taps : fill_ff + 1'b1;
   assign fire       = (fill_pre == taps);
   assign cell_ctl   = '{shift: accept, load: b_load};

   always_comb begin
      fill_in    = fill_ff;
      a_valid_in = a_valid_ff;
      b_valid_in = b_valid_ff;
      if (accept) begin
         fill_in    = req_ch.end_of_frame ? '0 : fill_pre;
         a_valid_in = fire;
      end else if (b_load) begin
         a_valid_in = 1'b0;
      end
      if (b_load) begin
         b_valid_in = 1'b1;
      end else if (sum_ready) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      if (b_load) begin
         b_resid_ff <= resid_sel;
      end
   end

   // row of sample cells, newest at cell 0
   assign chain[0] = req_ch.sample;

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      fsr_cell #(
         .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .sample_in  (chain[k]),
         .coef       (coef_sel[k]),
         .tap_used   (tap_used[k]),
         .sample_out (chain[k+1]),
         .product_out(product[k])
      );
   end

   fsr_sum #(
      .MAX_TAPS   (MAX_TAPS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_sum (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (b_valid_ff),
      .in_ready    (sum_ready),
      .products    (product),
      .resid_sample(b_resid_ff),
      .rsp_ch      (rsp_ch)
   );

endmodule

[hw/rtl/fsr_checker.sv]
`timescale 1ns / 1ps

module fsr_checker
   import fsr_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_filtered,
   input logic [SAMPLE_BITS:0]   rsp_residual
);

   // a stalled result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered) && $stable(rsp_residual))
      else $error("result beat changed while stalled");

   // input back-pressure only comes from a full pipe stalled at the output
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input held back with output free");

   // after reset, no result can appear before a beat has passed every pipe stage
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) || $past(reset, 2) || $past(reset, 3) |-> !rsp_valid)
      else $error("result too soon after reset");

   // an input beat is always taken when it is offered and the output flows
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_valid && rsp_ready |-> req_ready)
      else $error("input refused while output flows");

endmodule

bind fir_smoother_with_residual_top fsr_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_fsr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_filtered(rsp_ch.filtered),
   .rsp_residual(rsp_ch.residual_value)
);

[tb/tb_fir_smoother_with_residual_top.sv]
`timescale 1ns / 1ps

module tb_fir_smoother_with_residual_top;
   import fsr_pkg::*;

   localparam int     SB      = SAMPLE_BITS_DEF;
   localparam longint SMP_MAX = (longint'(1) << (SB - 1)) - 1;
   localparam longint SMP_MIN = -SMP_MAX - 1;
   localparam int     SETTLE  = 10;

   typedef struct packed {
      logic signed [SB-1:0] sample;
      logic                 eof;
   } frame_beat_type;

   typedef struct packed {
      logic signed [SB-1:0] filtered;
      logic signed [SB:0]   residual;
   } smooth_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fsr_req_if req_ch ();
   fsr_rsp_if rsp_ch ();
   fsr_csr_if csr_ch ();

   fir_smoother_with_residual_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   frame_beat_type sample_fifo[$];
   smooth_out_type smooth_due[$];

   // register shadow and filter window
   logic [TAP_BITS-1:0]    cfg_taps;
   offset_mode_type        cfg_mode;
   logic [OFFSET_BITS-1:0] cfg_fixed;
   logic signed [COEF_BITS-1:0] cfg_coef [MAX_TAPS_DEF];
   logic signed [SB-1:0]   win [MAX_TAPS_DEF];
   int                     win_fill;

   int  err_count = 0;
   int  hold_token = 0;
   bit  sender_steady = 1'b0;
   bit  req_fire = 1'b0;
   int  frame_left = 0;
   int  items_queued = 0;

   task automatic flag_mismatch(input string what);
      if (err_count < 50) $display("%0t mismatch: %s", $time, what);
      err_count++;
   endtask

   task automatic fir_step(input logic signed [SB-1:0] s, input logic eof);
      int             taps;
      int             drop;
      int             ofs;
      int             j;
      longint         acc;
      longint         f;
      longint         res;
      smooth_out_type r;
      if (cfg_taps == 0) taps = 1;
      else if (cfg_taps > MAX_TAPS_DEF) taps = MAX_TAPS_DEF;
      else taps = int'(cfg_taps);
      // tap count may have dropped since the last beat: keep the newest samples
      if (win_fill >= taps) begin
         drop = win_fill - taps + 1;
         for (j = 0; j + drop < win_fill; j++) win[j] = win[j + drop];
         win_fill = taps - 1;
      end
      win[win_fill] = s;
      win_fill++;
      if (win_fill == taps) begin
         acc = 0;
         for (j = 0; j < taps; j++) acc += longint'(cfg_coef[j]) * longint'(win[j]);
         // floor shift, so halves go toward +inf
         f = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
         if (f > SMP_MAX) f = SMP_MAX;
         if (f < SMP_MIN) f = SMP_MIN;
         case (cfg_mode)
            OFS_FIXED:  ofs = (int'(cfg_fixed) > taps - 1) ? taps - 1 : int'(cfg_fixed);
            OFS_NONE:   ofs = 0;
            OFS_MIDDLE: ofs = taps / 2;
            default:    ofs = taps - 1;
         endcase
         res = longint'(win[ofs]) - f;
         r.filtered = f[SB-1:0];
         r.residual = res[SB:0];
         smooth_due.push_back(r);
      end
      if (eof) begin
         for (j = 0; j < MAX_TAPS_DEF; j++) win[j] = '0;
         win_fill = 0;
      end
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         REG_TAP_COUNT:    cfg_taps  = val[TAP_BITS-1:0];
         REG_OFFSET_MODE:  cfg_mode  = offset_mode_type'(val[1:0]);
         REG_FIXED_OFFSET: cfg_fixed = val[OFFSET_BITS-1:0];
         default:          cfg_coef[idx - REG_COEF_BASE] = val;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic add_sample(input logic signed [SB-1:0] s, input logic eof);
      frame_beat_type b;
      b.sample = s;
      b.eof    = eof;
      sample_fifo.push_back(b);
      items_queued++;
   endtask

   // block idle: no beat pending, no result due, and the pipe given time to empty
   task automatic wait_quiet();
      while (sample_fifo.size() != 0 || smooth_due.size() != 0 || req_ch.valid)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic logic signed [SB-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return SB'(SMP_MAX);
         1:       return SB'(SMP_MIN);
         2:       return SB'($urandom_range(0, 64) - 32);
         default: return SB'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_coef();
      case ($urandom_range(0, 7))
         0:       return 16'h7fff;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'(2048 + $urandom_range(0, 6144));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_random_sample();
      logic eof;
      if (frame_left == 0) frame_left = $urandom_range(1, 30);
      eof = (frame_left == 1) || ($urandom_range(0, 99) < 3);
      frame_left = eof ? 0 : frame_left - 1;
      add_sample(pick_sample(), eof);
   endtask

   // accept side: predict on each input beat, check each result beat
   always @(posedge clock) begin
      smooth_out_type want;
      req_fire = !reset && req_ch.valid && req_ch.ready;
      if (req_fire) begin
         fir_step(req_ch.sample, req_ch.end_of_frame);
         void'(sample_fifo.pop_front());
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (smooth_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result filtered %0d residual %0d",
                                    rsp_ch.filtered, rsp_ch.residual_value));
         end else begin
            want = smooth_due.pop_front();
            if (rsp_ch.filtered !== want.filtered)
               flag_mismatch($sformatf("filtered got %0d exp %0d",
                                       rsp_ch.filtered, want.filtered));
            if (rsp_ch.residual_value !== want.residual)
               flag_mismatch($sformatf("residual got %0d exp %0d",
                                       rsp_ch.residual_value, want.residual));
         end
      end
   end

   // sample driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_fire) begin
         // beat still waiting for ready
      end else if (gap_left != 0 && !sender_steady) begin
         gap_left--;
         req_ch.valid <= 1'b0;
      end else if (sample_fifo.size() == 0) begin
         req_ch.valid <= 1'b0;
      end else begin
         req_ch.valid        <= 1'b1;
         req_ch.sample       <= sample_fifo[0].sample;
         req_ch.end_of_frame <= sample_fifo[0].eof;
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         end
      end
   end

   // result receiver: stretches at varying ready rates, plus long hold-offs on request
   int hold_seen = 0;
   int hold_left = 0;
   int stretch_left = 0;
   int ready_pct = 100;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = 120;
         end
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(10, 200);
            case ($urandom_range(0, 4))
               0, 1:    ready_pct = 100;
               2:       ready_pct = 75;
               3:       ready_pct = 40;
               default: ready_pct = 10;
            endcase
         end
         stretch_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) < ready_pct);
         end
      end
   end

   initial begin
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [CSR_DATA_BITS-1:0] d;
      int                       phase;
      int                       n;
      int                       k;
      req_ch.valid        = 1'b0;
      req_ch.sample       = '0;
      req_ch.end_of_frame = 1'b0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = '0;
      csr_ch.data         = '0;
      cfg_taps  = TAP_COUNT_RESET;
      cfg_mode  = OFS_NONE;
      cfg_fixed = '0;
      for (k = 0; k < MAX_TAPS_DEF; k++) begin
         cfg_coef[k] = '0;
         win[k]      = '0;
      end
      win_fill = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full-scale coefficients and samples, fixed offset past the window end
      csr_write(REG_TAP_COUNT, 16'd5);
      csr_write(REG_OFFSET_MODE, 16'(OFS_FIXED));
      csr_write(REG_FIXED_OFFSET, 16'd7);
      csr_write(REG_COEF_BASE, 16'h7fff);
      csr_write(REG_COEF_BASE + 3'd1, 16'h8000);
      csr_write(REG_COEF_BASE + 3'd2, 16'h4000);
      csr_write(REG_COEF_BASE + 3'd3, 16'hffff);
      csr_write(REG_COEF_BASE + 3'd4, 16'h0001);
      repeat (5) add_sample(SB'(SMP_MAX), 1'b0);
      add_sample(SB'(SMP_MIN), 1'b0);
      add_sample(SB'(SMP_MIN), 1'b0);
      add_sample(16'sd1, 1'b0);
      add_sample(-16'sd1, 1'b0);
      add_sample(16'sd0, 1'b1);
      wait_quiet();

      // tap count zero acts as one; half-way sums round upward
      csr_write(REG_TAP_COUNT, 16'hfff8);
      csr_write(REG_OFFSET_MODE, 16'(OFS_LAST));
      csr_write(REG_COEF_BASE, 16'h2000);
      add_sample(16'sd1, 1'b0);
      add_sample(-16'sd1, 1'b0);
      add_sample(16'sd3, 1'b0);
      add_sample(-16'sd3, 1'b0);
      add_sample(SB'(SMP_MAX), 1'b1);
      wait_quiet();

      // tap count above range, then lowered in the middle of a frame
      csr_write(REG_TAP_COUNT, 16'd7);
      csr_write(REG_OFFSET_MODE, 16'(OFS_MIDDLE));
      for (k = 1; k < MAX_TAPS_DEF; k++) csr_write(REG_COEF_BASE + 3'(k), pick_coef());
      repeat (4) add_sample(pick_sample(), 1'b0);
      wait_quiet();
      csr_write(REG_TAP_COUNT, 16'd2);
      csr_write(REG_OFFSET_MODE, 16'(OFS_FIXED));
      csr_write(REG_FIXED_OFFSET, 16'd1);
      add_sample(pick_sample(), 1'b0);
      add_sample(pick_sample(), 1'b0);
      add_sample(pick_sample(), 1'b1);
      wait_quiet();

      phase = 0;
      while (items_queued < 1275) begin
         wait_quiet();
         if ($urandom_range(0, 9) < 7) begin
            d = 16'($urandom);
            d[TAP_BITS-1:0] = 3'($urandom_range(0, 7));
            csr_write(REG_TAP_COUNT, d);
         end
         if ($urandom_range(0, 1) == 0) begin
            d = 16'($urandom);
            csr_write(REG_OFFSET_MODE, d);
         end
         if ($urandom_range(0, 4) < 2) begin
            d = 16'($urandom);
            csr_write(REG_FIXED_OFFSET, d);
         end
         for (k = 0; k < MAX_TAPS_DEF; k++)
            if ($urandom_range(0, 9) < 3) csr_write(REG_COEF_BASE + 3'(k), pick_coef());

         // every few phases the receiver blocks while samples keep coming
         if (phase % 6 == 3) begin
            sender_steady = 1'b1;
            hold_token++;
            n = $urandom_range(60, 100);
         end else begin
            sender_steady = (phase % 5 == 0);
            n = $urandom_range(20, 90);
         end
         repeat (n) add_random_sample();
         phase++;
      end

      wait_quiet();
      if (err_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
